// ----- design/lpi_pkg.sv -----
package lpi_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned SHIFT_W = 3;
  localparam int unsigned CFG_W   = 2;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd2;

  typedef enum logic [CFG_W-1:0] {
    CFG_RED_SHIFT   = 2'd0,
    CFG_GREEN_SHIFT = 2'd1,
    CFG_BLUE_SHIFT  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic               v;
    logic               first;
    logic               found;
    logic               app;
    logic [INDEX_W-1:0] idx;
    rgb_t               px;
  } stage_t;

endpackage

// ----- design/lpi_cell.sv -----
module lpi_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  lpi_pkg::rgb_t   mask,
  input  lpi_pkg::stage_t prev_stage,
  output lpi_pkg::stage_t next_stage
);

  logic            occupied;
  logic            occupied_next;
  lpi_pkg::rgb_t   color;
  lpi_pkg::stage_t stage;
  lpi_pkg::stage_t stage_next;
  logic            occ_eff;
  logic            live;
  logic            close;
  logic            hit;
  logic            take;

  always_comb begin
    occ_eff = occupied & ~prev_stage.first;
    live    = prev_stage.v & ~prev_stage.found;
    close   = (((color.r ^ prev_stage.px.r) & mask.r) == '0) &&
              (((color.g ^ prev_stage.px.g) & mask.g) == '0) &&
              (((color.b ^ prev_stage.px.b) & mask.b) == '0);
    hit     = live & occ_eff & close;
    take    = live & ~occ_eff;
  end

  always_comb begin
    occupied_next = prev_stage.v ? (occ_eff | take) : occupied;
    stage_next    = prev_stage;
    if (hit || take) begin
      stage_next.found = 1'b1;
      stage_next.idx   = lpi_pkg::INDEX_W'(INDEX);
    end
    stage_next.app = prev_stage.app | take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
      stage.v  <= 1'b0;
    end else if (advance) begin
      occupied <= occupied_next;
      stage    <= stage_next;
      if (take) begin
        color <= prev_stage.px;
      end
    end
  end

  assign next_stage = stage;

endmodule

// ----- design/lpi_result.sv -----
module lpi_result #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  lpi_pkg::stage_t               last_stage,
  output logic                          out_valid,
  output logic [lpi_pkg::INDEX_W-1:0]   palette_index,
  output logic                          new_entry,
  output logic                          overflow,
  output logic [lpi_pkg::COUNT_W-1:0]   entries_used
);

  logic                        ovf_seen;
  logic                        ovf_seen_next;
  logic [lpi_pkg::COUNT_W-1:0] count;
  logic [lpi_pkg::COUNT_W-1:0] count_next;
  logic [lpi_pkg::INDEX_W-1:0] index_next;
  logic                        new_entry_next;
  logic                        ovf_eff;
  logic [lpi_pkg::COUNT_W-1:0] count_eff;

  always_comb begin
    ovf_eff        = ovf_seen & ~last_stage.first;
    count_eff      = last_stage.first ? '0 : count;
    index_next     = '0;
    new_entry_next = 1'b0;
    ovf_seen_next  = 1'b1;
    count_next     = count_eff;
    if (!ovf_eff && last_stage.found) begin
      index_next     = last_stage.idx;
      new_entry_next = last_stage.app;
      ovf_seen_next  = 1'b0;
      count_next     = count_eff + lpi_pkg::COUNT_W'(last_stage.app);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ovf_seen  <= 1'b0;
      count     <= '0;
    end else if (advance) begin
      out_valid <= last_stage.v;
      if (last_stage.v) begin
        ovf_seen <= ovf_seen_next;
        count    <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_stage.v) begin
      palette_index <= index_next;
      new_entry     <= new_entry_next;
      overflow      <= ovf_seen_next;
      entries_used  <= count_next;
    end
  end

  a_new_not_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(new_entry && overflow))
    else $error("new entry reported together with overflow");

  a_ovf_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (palette_index == '0))
    else $error("nonzero index under overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= lpi_pkg::COUNT_W'(PALETTE_DEPTH))
    else $error("entry count beyond palette depth");

  a_new_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && new_entry) |->
      (entries_used == lpi_pkg::COUNT_W'(palette_index) + 1'b1))
    else $error("appended entry is not the newest");

endmodule

// ----- design/lossy_palette_indexer.sv -----
// Each pixel passes every palette cell register in order, then the result register.
// Throughput: one pixel per cycle; each pixel walks one palette cell per cycle.
// The whole cell chain holds while a finished result is stalled at the output.
// Reset clears every cell's occupied bit, the entry count, the overflow flag and
// sets all three channel shifts to 2; no clearing pass is needed.
module lossy_palette_indexer #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpi_pkg::CFG_W-1:0]     cfg_index,
  input  logic [lpi_pkg::SHIFT_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          first_of_image,
  input  logic [lpi_pkg::CHAN_W-1:0]    red,
  input  logic [lpi_pkg::CHAN_W-1:0]    green,
  input  logic [lpi_pkg::CHAN_W-1:0]    blue,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lpi_pkg::INDEX_W-1:0]   palette_index,
  output logic                          new_entry,
  output logic                          overflow,
  output logic [lpi_pkg::COUNT_W-1:0]   entries_used
);

  logic [lpi_pkg::SHIFT_W-1:0] red_shift;
  logic [lpi_pkg::SHIFT_W-1:0] green_shift;
  logic [lpi_pkg::SHIFT_W-1:0] blue_shift;
  lpi_pkg::rgb_t               mask;
  lpi_pkg::stage_t             chain [PALETTE_DEPTH+1];
  logic                        advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_shift   <= lpi_pkg::SHIFT_RESET;
      green_shift <= lpi_pkg::SHIFT_RESET;
      blue_shift  <= lpi_pkg::SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (lpi_pkg::cfg_idx_t'(cfg_index))
        lpi_pkg::CFG_RED_SHIFT:   red_shift   <= cfg_data;
        lpi_pkg::CFG_GREEN_SHIFT: green_shift <= cfg_data;
        lpi_pkg::CFG_BLUE_SHIFT:  blue_shift  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mask.r = {lpi_pkg::CHAN_W{1'b1}} << red_shift;
    mask.g = {lpi_pkg::CHAN_W{1'b1}} << green_shift;
    mask.b = {lpi_pkg::CHAN_W{1'b1}} << blue_shift;
  end

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  always_comb begin
    chain[0].v     = in_valid;
    chain[0].first = first_of_image;
    chain[0].found = 1'b0;
    chain[0].app   = 1'b0;
    chain[0].idx   = '0;
    chain[0].px.r  = red;
    chain[0].px.g  = green;
    chain[0].px.b  = blue;
  end

  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    lpi_cell #(
      .INDEX (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .mask       (mask),
      .prev_stage (chain[k]),
      .next_stage (chain[k+1])
    );
  end

  lpi_result #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_result (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .last_stage    (chain[PALETTE_DEPTH]),
    .out_valid     (out_valid),
    .palette_index (palette_index),
    .new_entry     (new_entry),
    .overflow      (overflow),
    .entries_used  (entries_used)
  );

endmodule
